[src/disk_image_header_decoder_macros.svh]
// assertion helpers for the disk image header decoder
`ifndef DISK_IMAGE_HEADER_DECODER_MACROS_SVH
`define DISK_IMAGE_HEADER_DECODER_MACROS_SVH

// condition and consequence in the same cycle
`define DIHD_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// consequence in the cycle after the condition
`define DIHD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/dihd_pkg.sv]
package dihd_pkg;

    // magic bytes and flag mask
    localparam logic [7:0] MAGIC_BYTE0  = 8'h96;
    localparam logic [7:0] MAGIC_BYTE1  = 8'h02;
    localparam logic [7:0] PROTECT_MASK = 8'h20;

    // header byte positions
    localparam logic [3:0] POS_MAGIC0   = 4'd0;
    localparam logic [3:0] POS_MAGIC1   = 4'd1;
    localparam logic [3:0] POS_PARA0    = 4'd2;
    localparam logic [3:0] POS_PARA1    = 4'd3;
    localparam logic [3:0] POS_SSIZE0   = 4'd4;
    localparam logic [3:0] POS_SSIZE1   = 4'd5;
    localparam logic [3:0] POS_PARA2    = 4'd6;
    localparam logic [3:0] POS_PARA3    = 4'd7;
    localparam logic [3:0] POS_FLAGS    = 4'd8;
    localparam logic [3:0] POS_LAST     = 4'd15;

    // sector size codes
    localparam logic [2:0] SZ_128  = 3'd0;
    localparam logic [2:0] SZ_256  = 3'd1;
    localparam logic [2:0] SZ_512  = 3'd2;
    localparam logic [2:0] SZ_1K   = 3'd3;
    localparam logic [2:0] SZ_2K   = 3'd4;
    localparam logic [2:0] SZ_4K   = 3'd5;
    localparam logic [2:0] SZ_8K   = 3'd6;

    // image size constants for 256-byte sectors
    localparam logic [35:0] IMG_BOOT_PAD  = 36'd384;
    localparam logic [35:0] IMG_SD_SPECIAL = 36'd184320;

    // decode error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_MAGIC       = 3'd1,
        ERR_SECTOR_SIZE = 3'd2,
        ERR_IMAGE_SIZE  = 3'd3,
        ERR_COUNT       = 3'd4
    } t_err;

    // collected header fields
    typedef struct packed {
        logic        magic_good;
        logic [31:0] paragraph_count;
        logic [15:0] sector_size_word;
        logic        protect_flag;
    } t_hdr_fields;

endpackage

[src/dihd_collect.sv]
module dihd_collect
    import dihd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_header_byte,
    output t_hdr_fields o_snap,
    output logic        o_snap_valid,
    input  logic        i_snap_take
);

    logic [3:0]  r_pos;
    t_hdr_fields r_hdr;
    t_hdr_fields n_hdr;
    t_hdr_fields r_snap;
    logic        r_snap_valid;
    logic        accept;

    // last byte waits only while an older header is still held
    assign o_ready = !((r_pos == POS_LAST) && r_snap_valid && !i_snap_take);
    assign accept  = i_valid && o_ready;

    // field capture per byte position
    always_comb begin
        n_hdr = r_hdr;
        unique case (r_pos)
            POS_MAGIC0: n_hdr.magic_good = (i_header_byte == MAGIC_BYTE0);
            POS_MAGIC1: n_hdr.magic_good = r_hdr.magic_good && (i_header_byte == MAGIC_BYTE1);
            POS_PARA0:  n_hdr.paragraph_count[7:0]   = i_header_byte;
            POS_PARA1:  n_hdr.paragraph_count[15:8]  = i_header_byte;
            POS_SSIZE0: n_hdr.sector_size_word[7:0]  = i_header_byte;
            POS_SSIZE1: n_hdr.sector_size_word[15:8] = i_header_byte;
            POS_PARA2:  n_hdr.paragraph_count[23:16] = i_header_byte;
            POS_PARA3:  n_hdr.paragraph_count[31:24] = i_header_byte;
            POS_FLAGS:  n_hdr.protect_flag = |(i_header_byte & PROTECT_MASK);
            default:    n_hdr = r_hdr;
        endcase
    end

    // position counter and snapshot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= r_pos + 4'd1;
            end
            if (accept && (r_pos == POS_LAST)) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    // header fields and snapshot handed to the decoder
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hdr <= n_hdr;
            if (r_pos == POS_LAST) begin
                r_snap <= r_hdr;
            end
        end
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

endmodule

[src/dihd_decode.sv]
`include "disk_image_header_decoder_macros.svh"

module dihd_decode
    import dihd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_hdr_fields i_snap,
    input  logic        i_snap_valid,
    output logic        o_snap_take,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_header_ok,
    output logic [2:0]  o_error_code,
    output logic [2:0]  o_sector_size_code,
    output logic [15:0] o_sector_count,
    output logic [15:0] o_sectors_per_track,
    output logic [6:0]  o_tracks_per_side,
    output logic [1:0]  o_side_count,
    output logic        o_write_protected
);

    logic        r_out_valid;
    logic        r_header_ok;
    t_err        r_error_code;
    logic [2:0]  r_sector_size_code;
    logic [15:0] r_sector_count;
    logic [15:0] r_sectors_per_track;
    logic [6:0]  r_tracks_per_side;
    logic [1:0]  r_side_count;
    logic        r_write_protected;

    logic        n_header_ok;
    t_err        n_error_code;
    logic [2:0]  n_sector_size_code;
    logic [15:0] n_sector_count;
    logic [15:0] n_sectors_per_track;
    logic [6:0]  n_tracks_per_side;
    logic [1:0]  n_side_count;
    logic        n_write_protected;

    logic [35:0] img;
    logic [36:0] img_padded;
    logic [2:0]  code;
    logic        code_ok;
    logic [3:0]  shift;
    logic [35:0] low_mask;
    logic        size_bad;
    logic [36:0] count_wide;
    logic        count_bad;
    logic [15:0] count;

    assign o_snap_take = i_snap_valid && (!r_out_valid || i_ready);

    // sector size word to size code
    always_comb begin
        code    = SZ_128;
        code_ok = 1'b1;
        unique case (i_snap.sector_size_word)
            16'h0080: code = SZ_128;
            16'h0100: code = SZ_256;
            16'h0200: code = SZ_512;
            16'h0400: code = SZ_1K;
            16'h0800: code = SZ_2K;
            16'h1000: code = SZ_4K;
            16'h2000: code = SZ_8K;
            default:  code_ok = 1'b0;
        endcase
    end

    // image size and sector count
    assign img        = {i_snap.paragraph_count, 4'b0000};
    assign img_padded = {1'b0, img} + {1'b0, IMG_BOOT_PAD};
    assign shift      = {1'b0, code} + 4'd7;
    assign low_mask   = (36'd1 << shift) - 36'd1;

    always_comb begin
        size_bad   = 1'b0;
        count_wide = '0;
        if (code == SZ_256) begin
            if (img <= IMG_BOOT_PAD) begin
                size_bad = 1'b1;
            end else if (img == IMG_SD_SPECIAL) begin
                count_wide = 37'd720;
            end else if (img_padded[7:0] != 8'd0) begin
                size_bad = 1'b1;
            end else begin
                count_wide = img_padded >> 8;
            end
        end else begin
            size_bad   = (img & low_mask) != 36'd0;
            count_wide = {1'b0, img >> shift};
        end
    end

    assign count_bad = (count_wide == 37'd0) || (count_wide[36:16] != 21'd0);
    assign count     = count_wide[15:0];

    // result fields with error priority
    always_comb begin
        n_header_ok         = 1'b0;
        n_error_code        = ERR_NONE;
        n_sector_size_code  = '0;
        n_sector_count      = '0;
        n_sectors_per_track = '0;
        n_tracks_per_side   = '0;
        n_side_count        = '0;
        n_write_protected   = 1'b0;
        priority if (!i_snap.magic_good) begin
            n_error_code = ERR_MAGIC;
        end else if (!code_ok) begin
            n_error_code = ERR_SECTOR_SIZE;
        end else if (size_bad) begin
            n_error_code = ERR_IMAGE_SIZE;
        end else if (count_bad) begin
            n_error_code = ERR_COUNT;
        end else begin
            n_header_ok         = 1'b1;
            n_sector_size_code  = code;
            n_sector_count      = count;
            n_sectors_per_track = count;
            n_tracks_per_side   = 7'd1;
            n_side_count        = 2'd1;
            n_write_protected   = i_snap.protect_flag;
            // known layouts
            if ((code == SZ_128) || (code == SZ_256)) begin
                unique case (count)
                    16'd720: begin
                        n_sectors_per_track = 16'd18;
                        n_tracks_per_side   = 7'd40;
                    end
                    16'd1040: begin
                        n_sectors_per_track = 16'd26;
                        n_tracks_per_side   = 7'd40;
                    end
                    16'd1440: begin
                        n_sectors_per_track = 16'd18;
                        n_tracks_per_side   = 7'd40;
                        n_side_count        = 2'd2;
                    end
                    16'd2880: begin
                        n_sectors_per_track = 16'd18;
                        n_tracks_per_side   = 7'd80;
                        n_side_count        = 2'd2;
                    end
                    16'd5760: begin
                        n_sectors_per_track = 16'd36;
                        n_tracks_per_side   = 7'd80;
                        n_side_count        = 2'd2;
                    end
                    default: begin
                        n_sectors_per_track = count;
                    end
                endcase
            end else if (code == SZ_512) begin
                unique case (count)
                    16'd720: begin
                        n_sectors_per_track = 16'd9;
                        n_tracks_per_side   = 7'd80;
                    end
                    16'd1440: begin
                        n_sectors_per_track = 16'd9;
                        n_tracks_per_side   = 7'd80;
                        n_side_count        = 2'd2;
                    end
                    16'd2880: begin
                        n_sectors_per_track = 16'd18;
                        n_tracks_per_side   = 7'd80;
                        n_side_count        = 2'd2;
                    end
                    default: begin
                        n_sectors_per_track = count;
                    end
                endcase
            end
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_snap_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_header_ok         <= n_header_ok;
            r_error_code        <= n_error_code;
            r_sector_size_code  <= n_sector_size_code;
            r_sector_count      <= n_sector_count;
            r_sectors_per_track <= n_sectors_per_track;
            r_tracks_per_side   <= n_tracks_per_side;
            r_side_count        <= n_side_count;
            r_write_protected   <= n_write_protected;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_header_ok         = r_header_ok;
    assign o_error_code        = r_error_code;
    assign o_sector_size_code  = r_sector_size_code;
    assign o_sector_count      = r_sector_count;
    assign o_sectors_per_track = r_sectors_per_track;
    assign o_tracks_per_side   = r_tracks_per_side;
    assign o_side_count        = r_side_count;
    assign o_write_protected   = r_write_protected;

    // a good result carries no error code and a real geometry
    `DIHD_ASSERT_NOW(a_ok_consistent, i_clk, i_rst_n,
        r_out_valid && r_header_ok,
        (r_error_code == ERR_NONE) && (r_sector_count != 16'd0) && (r_side_count != 2'd0),
        "good result with error code or empty geometry")
    // a failed result carries an error code and zeroed fields
    `DIHD_ASSERT_NOW(a_err_consistent, i_clk, i_rst_n,
        r_out_valid && !r_header_ok,
        (r_error_code != ERR_NONE) && (r_sector_count == 16'd0) && (r_side_count == 2'd0),
        "failed result without error code or with geometry")
    // a held header is not dropped while the result register is busy
    `DIHD_ASSERT_NEXT(a_snap_kept, i_clk, i_rst_n,
        i_snap_valid && !o_snap_take,
        i_snap_valid,
        "pending header lost before transfer into result register")
    // a taken header always shows up as a result
    `DIHD_ASSERT_NEXT(a_take_shows, i_clk, i_rst_n,
        o_snap_take,
        r_out_valid,
        "header taken but no result presented")

endmodule

[src/disk_image_header_decoder.sv]
// disk image header decoder
// input channel: i_valid / o_ready with i_header_byte, the 16 header bytes
//   of one image in order; a header follows the previous one directly
// output channel: o_valid / i_ready with one decode result per header,
//   presented after the last header byte (byte 15)
// throughput: one header byte per cycle while o_ready is high
// the result is registered: the header snapshot loads at the transfer of
//   byte 15, and the decode logic fills the result register from the
//   snapshot once the result register is free
// a stalled receiver holds the result; the next header is still taken in
//   while the previous one waits in the snapshot stage, and only byte 15
//   of a further header waits for the result register to free up
// on error o_header_ok is low, o_error_code gives the first failing check
//   and every other field is zero
// reset (i_rst_n low, synchronous) returns the byte position to 0 and
//   drops any pending or presented result
module disk_image_header_decoder
    import dihd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_header_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_header_ok,
    output logic [2:0]  o_error_code,
    output logic [2:0]  o_sector_size_code,
    output logic [15:0] o_sector_count,
    output logic [15:0] o_sectors_per_track,
    output logic [6:0]  o_tracks_per_side,
    output logic [1:0]  o_side_count,
    output logic        o_write_protected
);

    t_hdr_fields snap;
    logic        snap_valid;
    logic        snap_take;

    // byte collection and header snapshot
    dihd_collect u_collect (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_header_byte (i_header_byte),
        .o_snap        (snap),
        .o_snap_valid  (snap_valid),
        .i_snap_take   (snap_take)
    );

    // decode and result register
    dihd_decode u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_snap              (snap),
        .i_snap_valid        (snap_valid),
        .o_snap_take         (snap_take),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_header_ok         (o_header_ok),
        .o_error_code        (o_error_code),
        .o_sector_size_code  (o_sector_size_code),
        .o_sector_count      (o_sector_count),
        .o_sectors_per_track (o_sectors_per_track),
        .o_tracks_per_side   (o_tracks_per_side),
        .o_side_count        (o_side_count),
        .o_write_protected   (o_write_protected)
    );

endmodule

[bench/disk_image_header_decoder_tb.sv]
module disk_image_header_decoder_tb
    import dihd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          RANDOM_HEADERS = 2;
    localparam int          RX_HOLD_CYCLES = 400;

    // counts that the layout table knows
    localparam logic [15:0] CNT_SD   = 16'd720;
    localparam logic [15:0] CNT_ED   = 16'd1040;
    localparam logic [15:0] CNT_DD   = 16'd1440;
    localparam logic [15:0] CNT_QD   = 16'd2880;
    localparam logic [15:0] CNT_HD   = 16'd5760;

    // one decode result as seen on the output ports
    typedef struct packed {
        logic        ok;
        t_err        err;
        logic [2:0]  size_code;
        logic [15:0] count;
        logic [15:0] per_track;
        logic [6:0]  tracks;
        logic [1:0]  sides;
        logic        protect;
    } t_decode;

    // header predictor and result checker
    class header_decode_checker;
        logic [3:0]  byte_pos;
        logic        magic_ok;
        logic [31:0] para_count;
        logic [15:0] size_word;
        logic        protect_bit;
        t_decode     expected_decodes[$];
        int          errors;
        int          decodes_checked;
        int          kind_seen[5];

        function new();
            byte_pos    = '0;
            magic_ok    = 1'b0;
            para_count  = '0;
            size_word   = '0;
            protect_bit = 1'b0;
            errors      = 0;
            decodes_checked = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function t_decode decode_header();
            t_decode     r;
            logic        found;
            logic [2:0]  szc;
            logic [63:0] img;
            logic [63:0] cnt;
            r     = '0;
            found = 1'b0;
            szc   = '0;
            if (!magic_ok) begin
                r.err = ERR_MAGIC;
                return r;
            end
            for (int k = 0; k < 7; k++) begin
                if (size_word == (16'd128 << k)) begin
                    found = 1'b1;
                    szc   = 3'(k);
                end
            end
            if (!found) begin
                r.err = ERR_SECTOR_SIZE;
                return r;
            end
            img = {28'd0, para_count, 4'd0};
            if (szc == SZ_256) begin
                // padded boot sectors, with the plain single density size as exception
                if (img <= 64'd384) begin
                    r.err = ERR_IMAGE_SIZE;
                    return r;
                end
                if (img == 64'd184320) begin
                    cnt = 64'(CNT_SD);
                end else begin
                    img = img + 64'd384;
                    if (img[7:0] != 8'd0) begin
                        r.err = ERR_IMAGE_SIZE;
                        return r;
                    end
                    cnt = img >> 8;
                end
            end else begin
                if ((img & ((64'd1 << (szc + 7)) - 64'd1)) != 64'd0) begin
                    r.err = ERR_IMAGE_SIZE;
                    return r;
                end
                cnt = img >> (szc + 7);
            end
            if (cnt == 64'd0 || cnt >= 64'd65536) begin
                r.err = ERR_COUNT;
                return r;
            end
            r.ok        = 1'b1;
            r.err       = ERR_NONE;
            r.size_code = szc;
            r.count     = cnt[15:0];
            r.per_track = cnt[15:0];
            r.tracks    = 7'd1;
            r.sides     = 2'd1;
            r.protect   = protect_bit;
            // geometry from the layout table
            if (szc == SZ_128 || szc == SZ_256) begin
                case (cnt[15:0])
                    CNT_SD: begin r.per_track = 16'd18; r.tracks = 7'd40; end
                    CNT_ED: begin r.per_track = 16'd26; r.tracks = 7'd40; end
                    CNT_DD: begin
                        r.per_track = 16'd18; r.tracks = 7'd40; r.sides = 2'd2;
                    end
                    CNT_QD: begin
                        r.per_track = 16'd18; r.tracks = 7'd80; r.sides = 2'd2;
                    end
                    CNT_HD: begin
                        r.per_track = 16'd36; r.tracks = 7'd80; r.sides = 2'd2;
                    end
                    default: ;
                endcase
            end else if (szc == SZ_512) begin
                case (cnt[15:0])
                    CNT_SD: begin r.per_track = 16'd9; r.tracks = 7'd80; end
                    CNT_DD: begin
                        r.per_track = 16'd9; r.tracks = 7'd80; r.sides = 2'd2;
                    end
                    CNT_QD: begin
                        r.per_track = 16'd18; r.tracks = 7'd80; r.sides = 2'd2;
                    end
                    default: ;
                endcase
            end
            return r;
        endfunction

        // accepted header byte
        function void note_byte(logic [7:0] b);
            case (byte_pos)
                POS_MAGIC0: magic_ok = (b == MAGIC_BYTE0);
                POS_MAGIC1: magic_ok = magic_ok && (b == MAGIC_BYTE1);
                POS_PARA0:  para_count[7:0]   = b;
                POS_PARA1:  para_count[15:8]  = b;
                POS_SSIZE0: size_word[7:0]    = b;
                POS_SSIZE1: size_word[15:8]   = b;
                POS_PARA2:  para_count[23:16] = b;
                POS_PARA3:  para_count[31:24] = b;
                POS_FLAGS:  protect_bit = |(b & PROTECT_MASK);
                POS_LAST:   expected_decodes.push_back(decode_header());
                default: ;
            endcase
            byte_pos = byte_pos + 4'd1;
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= 10)
                    $display("decode %0d: %s expected %0d, got %0d",
                             decodes_checked, field, want, got);
            end
        endfunction

        // accepted decode result against the oldest prediction
        function void check_result(t_decode got);
            t_decode want;
            if (expected_decodes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("decode result with nothing expected: err %0d count %0d",
                             got.err, got.count);
                return;
            end
            want = expected_decodes.pop_front();
            compare_field("header_ok", want.ok, got.ok);
            compare_field("error_code", want.err, got.err);
            compare_field("sector_size_code", want.size_code, got.size_code);
            compare_field("sector_count", want.count, got.count);
            compare_field("sectors_per_track", want.per_track, got.per_track);
            compare_field("tracks_per_side", want.tracks, got.tracks);
            compare_field("side_count", want.sides, got.sides);
            compare_field("write_protected", want.protect, got.protect);
            kind_seen[want.err]++;
            decodes_checked++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_header_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_header_ok;
    logic [2:0]  o_error_code;
    logic [2:0]  o_sector_size_code;
    logic [15:0] o_sector_count;
    logic [15:0] o_sectors_per_track;
    logic [6:0]  o_tracks_per_side;
    logic [1:0]  o_side_count;
    logic        o_write_protected;

    header_decode_checker hdr_check = new();
    logic [7:0]  header_stream[$];
    int unsigned cycle_count = 0;
    int          headers_built = 0;

    disk_image_header_decoder uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_header_byte       (i_header_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_header_ok         (o_header_ok),
        .o_error_code        (o_error_code),
        .o_sector_size_code  (o_sector_size_code),
        .o_sector_count      (o_sector_count),
        .o_sectors_per_track (o_sectors_per_track),
        .o_tracks_per_side   (o_tracks_per_side),
        .o_side_count        (o_side_count),
        .o_write_protected   (o_write_protected)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // paragraph count for a wanted sector count at a given sector size
    function automatic logic [31:0] para_for(logic [2:0] szc, logic [35:0] cnt);
        logic [35:0] img;
        if (szc == SZ_256)
            img = (cnt << 8) - 36'd384;
        else
            img = cnt << (szc + 7);
        return img[35:4];
    endfunction

    // queue one 16-byte header, unused bytes random
    task automatic add_header(input logic [7:0] m0, input logic [7:0] m1,
                              input logic [31:0] para, input logic [15:0] ssw,
                              input logic [7:0] flags);
        header_stream.push_back(m0);
        header_stream.push_back(m1);
        header_stream.push_back(para[7:0]);
        header_stream.push_back(para[15:8]);
        header_stream.push_back(ssw[7:0]);
        header_stream.push_back(ssw[15:8]);
        header_stream.push_back(para[23:16]);
        header_stream.push_back(para[31:24]);
        header_stream.push_back(flags);
        for (int k = 9; k < 16; k++)
            header_stream.push_back(8'($urandom));
        headers_built++;
    endtask

    // mostly well-formed headers with random content, some broken, some noise
    task automatic add_random_header();
        int          kind;
        logic [2:0]  szc;
        logic [35:0] cnt;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [31:0] para;
        logic [15:0] ssw;
        logic [15:0] known[5];
        known = '{CNT_SD, CNT_ED, CNT_DD, CNT_QD, CNT_HD};
        kind  = $urandom_range(0, 99);
        m0    = MAGIC_BYTE0;
        m1    = MAGIC_BYTE1;
        szc   = 3'($urandom_range(0, 6));
        cnt   = ($urandom_range(0, 3) == 0) ? 36'($urandom_range(1, 65535))
                                            : 36'($urandom_range(1, 3000));
        if (kind < 25) begin
            szc = 3'($urandom_range(0, 2));
            cnt = 36'(known[$urandom_range(0, 4)]);
        end else if (kind >= 84 && kind < 90) begin
            cnt = 36'($urandom_range(65536, 1 << 22));
        end
        if (szc == SZ_256 && cnt < 36'd4)
            cnt = cnt + 36'd4;
        para = para_for(szc, cnt);
        ssw  = 16'd128 << szc;
        if (kind < 25 && szc == SZ_256 && cnt == 36'(CNT_SD) && $urandom_range(0, 1))
            para = 32'd11520;
        if (kind >= 60 && kind < 68) begin
            if ($urandom_range(0, 1)) m0 = 8'($urandom); else m1 = 8'($urandom);
        end else if (kind >= 68 && kind < 76) begin
            ssw = 16'($urandom);
        end else if (kind >= 76 && kind < 84) begin
            para = $urandom;
        end else if (kind >= 84 && kind < 90 && szc != SZ_256 && $urandom_range(0, 3) == 0) begin
            para = '0;
        end else if (kind >= 90) begin
            m0   = $urandom_range(0, 1) ? MAGIC_BYTE0 : 8'($urandom);
            m1   = 8'($urandom);
            para = $urandom;
            ssw  = 16'($urandom);
        end
        add_header(m0, m1, para, ssw, 8'($urandom));
    endtask

    // offer the queued header bytes with random gaps
    task automatic send_header_bytes();
        int gap;
        bit quiet;
        quiet = 1'b0;
        for (int n = 0; n < header_stream.size(); n++) begin
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid       <= 1'b1;
            i_header_byte <= header_stream[n];
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            hdr_check.note_byte(header_stream[n]);
        end
        i_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin : result_sink
        int      stall;
        bit      held;
        bit      quiet;
        t_decode got;
        held    = 1'b0;
        quiet   = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) quiet = !quiet;
            if (!held && hdr_check.decodes_checked == 4) begin
                held  = 1'b1;
                stall = RX_HOLD_CYCLES;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got.ok        = o_header_ok;
            got.err       = t_err'(o_error_code);
            got.size_code = o_sector_size_code;
            got.count     = o_sector_count;
            got.per_track = o_sectors_per_track;
            got.tracks    = o_tracks_per_side;
            got.sides     = o_side_count;
            got.protect   = o_write_protected;
            hdr_check.check_result(got);
        end
    end

    // reset, stimulus and end of run
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_header_byte <= 8'h00;

        // magic checks and extreme bytes
        add_header(8'h00, 8'h00, 32'h0, 16'h0, 8'h00);
        add_header(8'hff, 8'hff, 32'hffffffff, 16'hffff, 8'hff);
        add_header(MAGIC_BYTE0, 8'h03, para_for(SZ_128, 720), 16'd128, 8'h00);
        add_header(8'h97, MAGIC_BYTE1, para_for(SZ_128, 720), 16'd128, 8'h00);
        // sector size words that are not allowed
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 720), 16'd0, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 720), 16'hffff, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 720), 16'd384, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_8K, 4), 16'd16384, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 720), 16'd64, 8'h00);
        // 256-byte sectors: plain single density size, too small, off boundary, padded sizes
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'd11520, 16'd256, PROTECT_MASK);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'd24, 16'd256, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'd0, 16'd256, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'd25, 16'd256, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 4), 16'd256, 8'hdf);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 720), 16'd256, 8'h20);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 1040), 16'd256, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 1440), 16'd256, 8'hff);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 2880), 16'd256, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_256, 5760), 16'd256, 8'h00);
        // padding carries past 36 bits
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'hffffffe8, 16'd256, 8'h00);
        // 128-byte and 512-byte layouts
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 720), 16'd128, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 1040), 16'd128, 8'h20);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 5760), 16'd128, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_512, 720), 16'd512, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_512, 1440), 16'd512, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_512, 2880), 16'd512, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_512, 1040), 16'd512, 8'h00);
        // larger sectors, count limits
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_1K, 1440), 16'd1024, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_2K, 1), 16'd2048, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_4K, 3), 16'd4096, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_8K, 65535), 16'd8192, 8'h20);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 65536), 16'd128, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'd0, 16'd128, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'hffffffff, 16'd8192, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, 32'hffffffe0, 16'd512, 8'h00);
        add_header(MAGIC_BYTE0, MAGIC_BYTE1, para_for(SZ_128, 1) + 32'd1, 16'd128, 8'h00);

        for (int h = 0; h < RANDOM_HEADERS; h++)
            add_random_header();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_header_bytes();
        while (hdr_check.expected_decodes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d headers (%0d bytes) sent, %0d decodes checked in %0d cycles",
                 headers_built, header_stream.size(), hdr_check.decodes_checked,
                 cycle_count);
        $display("outcomes: ok %0d, magic %0d, sector size %0d, image size %0d, range %0d",
                 hdr_check.kind_seen[ERR_NONE], hdr_check.kind_seen[ERR_MAGIC],
                 hdr_check.kind_seen[ERR_SECTOR_SIZE], hdr_check.kind_seen[ERR_IMAGE_SIZE],
                 hdr_check.kind_seen[ERR_COUNT]);
        if (hdr_check.errors == 0 && hdr_check.expected_decodes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", hdr_check.errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/dihd_pkg.sv
src/dihd_collect.sv
src/dihd_decode.sv
src/disk_image_header_decoder.sv
bench/disk_image_header_decoder_tb.sv
